// ----- rtl/mbir_pkg.sv -----
// Shared types and constants for the mapper bank and IRQ register block.
// Holds the request and result word layouts, register indexes and decode codes.
// No dependencies.
package mbir_pkg;

  typedef struct packed {
    logic        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_word_t;

  typedef struct packed {
    logic       irq_line;
    logic       bank_updated;
    logic [3:0] bank_slot;
    logic [7:0] bank_value;
    logic       sound_write;
    logic       sound_port;
    logic [7:0] sound_data;
    logic [1:0] mirroring;
    logic       wram_enable;
  } rsp_word_t;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_A0_MASK    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_A1_MASK    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ASSERT_DLY = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration reset values
  localparam logic [15:0] A0_MASK_RESET    = 16'h0010;
  localparam logic [15:0] A1_MASK_RESET    = 16'h0020;
  localparam logic [7:0]  ASSERT_DLY_RESET = 8'd1;

  // address nibble codes
  localparam logic [3:0] NIB_PRG_LO    = 4'h8;
  localparam logic [3:0] NIB_PRG_HI    = 4'h9;
  localparam logic [3:0] NIB_CHR_FIRST = 4'hA;
  localparam logic [3:0] NIB_CHR_LAST  = 4'hD;
  localparam logic [3:0] NIB_CTRL      = 4'hE;
  localparam logic [3:0] NIB_IRQ       = 4'hF;

  localparam logic [3:0] PRG_SLOT_SOUND = 4'd3;
  localparam logic [3:0] CHR_SLOT_BASE  = 4'd3;

  // IRQ prescaler and counter
  localparam logic [8:0] PRESCALE_LIMIT = 9'd338;
  localparam logic [8:0] PRESCALE_STEP  = 9'd3;
  localparam logic [7:0] COUNTER_TOP    = 8'hFF;

endpackage

// ----- rtl/mapper_bank_and_irq_registers_core.sv -----
// Results are registered; one goes to the skid register while a result waits.
// One request word per cycle while in_stall is low; IRQ state updates on accept.
// A two-entry output stage (result register plus skid register) lets a request
// be accepted while a result waits; in_stall rises only when both entries are full.
// Synchronous active-high reset restores configuration and IRQ state defaults
// and empties the output stage.
module mapper_bank_and_irq_registers_core
  import mbir_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  req_word_t              in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rsp_word_t              out_word,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic [15:0] a0_mask;
  logic [15:0] a1_mask;
  logic [7:0]  irq_assert_dly;

  // IRQ and control state
  logic [7:0] control_reg, control_reg_next;
  logic [7:0] irq_reload, irq_reload_next;
  logic [7:0] irq_counter, irq_counter_next;
  logic [8:0] prescale_acc, prescale_acc_next;
  logic       irq_running, irq_running_next;
  logic       cycle_mode, cycle_mode_next;
  logic       ack_restart, ack_restart_next;
  logic [7:0] delay_left, delay_left_next;
  logic       irq_level, irq_level_next;

  // output stage
  logic      skid_valid;
  rsp_word_t skid_word;
  rsp_word_t rsp_next;
  logic      in_acc;
  logic      out_take;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a0_mask        <= A0_MASK_RESET;
      a1_mask        <= A1_MASK_RESET;
      irq_assert_dly <= ASSERT_DLY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_A0_MASK:    a0_mask        <= cfg_data;
        CFG_A1_MASK:    a1_mask        <= cfg_data;
        CFG_ASSERT_DLY: irq_assert_dly <= cfg_data[7:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    logic [3:0] nib;
    logic       a0;
    logic       a1;
    logic [3:0] chr_off;
    logic       do_count;

    nib      = in_word.address[15:12];
    a0       = (in_word.address & a0_mask) != 16'd0;
    a1       = (in_word.address & a1_mask) != 16'd0;
    chr_off  = nib - NIB_CHR_FIRST;
    do_count = 1'b0;

    control_reg_next  = control_reg;
    irq_reload_next   = irq_reload;
    irq_counter_next  = irq_counter;
    prescale_acc_next = prescale_acc;
    irq_running_next  = irq_running;
    cycle_mode_next   = cycle_mode;
    ack_restart_next  = ack_restart;
    delay_left_next   = delay_left;
    irq_level_next    = irq_level;

    rsp_next = '0;

    if (in_word.req_type == REQ_TICK) begin
      if (delay_left != 8'd0) begin
        delay_left_next = delay_left - 8'd1;
        if (delay_left == 8'd1) begin
          irq_level_next = 1'b1;
        end
      end
      if (irq_running) begin
        if (cycle_mode) begin
          do_count = 1'b1;
        end else if (prescale_acc < PRESCALE_LIMIT) begin
          prescale_acc_next = prescale_acc + PRESCALE_STEP;
        end else begin
          prescale_acc_next = prescale_acc - PRESCALE_LIMIT;
          do_count = 1'b1;
        end
      end
      if (do_count) begin
        if (irq_counter != COUNTER_TOP) begin
          irq_counter_next = irq_counter + 8'd1;
        end else begin
          // overflow: reload and arm the assertion delay
          irq_counter_next = irq_reload;
          delay_left_next  = irq_assert_dly;
        end
      end
    end else begin
      if (nib == NIB_PRG_LO || nib == NIB_PRG_HI) begin
        if (nib == NIB_PRG_HI && a0) begin
          rsp_next.sound_write = 1'b1;
          rsp_next.sound_port  = a1;
          rsp_next.sound_data  = in_word.write_data;
        end else begin
          rsp_next.bank_updated = 1'b1;
          rsp_next.bank_slot    = {2'b00, nib[0], a0};
          rsp_next.bank_value   = in_word.write_data;
        end
      end else if (nib >= NIB_CHR_FIRST && nib <= NIB_CHR_LAST) begin
        rsp_next.bank_updated = 1'b1;
        rsp_next.bank_slot    = CHR_SLOT_BASE + {1'b0, chr_off[1:0], a0};
        rsp_next.bank_value   = in_word.write_data;
      end else if (nib == NIB_CTRL) begin
        if (a0) begin
          irq_reload_next = in_word.write_data;
        end else begin
          control_reg_next = in_word.write_data;
        end
      end else if (nib == NIB_IRQ) begin
        if (a0) begin
          irq_running_next = ack_restart;
        end else begin
          ack_restart_next = in_word.write_data[0];
          irq_running_next = in_word.write_data[1];
          cycle_mode_next  = in_word.write_data[2];
          if (in_word.write_data[1]) begin
            prescale_acc_next = 9'd0;
            irq_counter_next  = irq_reload;
          end
        end
        // acknowledge; a pending delay keeps counting
        irq_level_next = 1'b0;
      end
    end

    rsp_next.irq_line    = irq_level_next;
    rsp_next.mirroring   = control_reg_next[1:0];
    rsp_next.wram_enable = control_reg_next[7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg  <= 8'd0;
      irq_reload   <= 8'd0;
      irq_counter  <= 8'd0;
      prescale_acc <= 9'd0;
      irq_running  <= 1'b0;
      cycle_mode   <= 1'b0;
      ack_restart  <= 1'b0;
      delay_left   <= 8'd0;
      irq_level    <= 1'b0;
    end else if (in_acc) begin
      control_reg  <= control_reg_next;
      irq_reload   <= irq_reload_next;
      irq_counter  <= irq_counter_next;
      prescale_acc <= prescale_acc_next;
      irq_running  <= irq_running_next;
      cycle_mode   <= cycle_mode_next;
      ack_restart  <= ack_restart_next;
      delay_left   <= delay_left_next;
      irq_level    <= irq_level_next;
    end
  end

  // output stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (in_acc) begin
        out_word <= rsp_next;
      end
    end else if (in_acc) begin
      skid_word <= rsp_next;
    end
  end

endmodule

// ----- rtl/mbir_checker.sv -----
// Port-level checks for the mapper bank and IRQ register block.
// Depends on mbir_pkg; bound to mapper_bank_and_irq_registers_core below.
module mbir_checker
  import mbir_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input req_word_t              in_word,
  input logic                   out_valid,
  input logic                   out_stall,
  input rsp_word_t              out_word,
  input logic                   cfg_we,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output stage not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_bank_or_sound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.bank_updated && out_word.sound_write))
    else $error("word both updates a bank and writes the sound port");

  a_bank_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.bank_updated |->
      out_word.bank_slot == 4'd0 && out_word.bank_value == 8'd0)
    else $error("bank fields set without a bank update");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.bank_updated |-> out_word.bank_slot <= 4'd10)
    else $error("bank slot out of range");

endmodule

bind mapper_bank_and_irq_registers_core mbir_checker u_mbir_checker (.*);

// ----- test/tb.sv -----
// Self-checking bench for mapper_bank_and_irq_registers_core: bank, sound port,
// control and IRQ counter behavior checked word by word against an in-bench predictor.
// Depends on mbir_pkg and the core module only.
module tb;
  import mbir_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IRQ_RESTART_BIT = 0;
  localparam int IRQ_RUN_BIT     = 1;
  localparam int IRQ_CYCLE_BIT   = 2;
  localparam int WRAM_EN_BIT     = 7;
  localparam int NUM_PHASES      = 10;
  localparam int PHASE_WORDS     = 185;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  req_word_t              in_word = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  rsp_word_t              out_word;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of configuration and state
  logic [15:0] a0_mask = A0_MASK_RESET;
  logic [15:0] a1_mask = A1_MASK_RESET;
  logic [7:0]  assert_delay = ASSERT_DLY_RESET;
  logic [7:0]  ctrl_reg = '0;
  logic [7:0]  reload_val = '0;
  logic [7:0]  irq_cnt = '0;
  logic [8:0]  presc = '0;
  logic        running = 1'b0;
  logic        cyc_mode = 1'b0;
  logic        restart_on_ack = 1'b0;
  logic [7:0]  delay_cnt = '0;
  logic        irq_lvl = 1'b0;

  req_word_t pending_req_q[$];
  rsp_word_t expected_rsp_q[$];
  int burst_left = 0;
  int gap_left = 0;
  int rcv_left = 0;
  int mismatch_cnt = 0;
  int rsp_cnt = 0;

  mapper_bank_and_irq_registers_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void advance_irq_counter();
    logic fire;
    fire = 1'b1;
    if (delay_cnt != 0) begin
      delay_cnt = delay_cnt - 8'd1;
      if (delay_cnt == 0) irq_lvl = 1'b1;
    end
    if (running) begin
      if (!cyc_mode) begin
        if (presc < PRESCALE_LIMIT) begin
          presc = presc + PRESCALE_STEP;
          fire = 1'b0;
        end else begin
          presc = presc - PRESCALE_LIMIT;
        end
      end
      if (fire) begin
        if (irq_cnt != COUNTER_TOP) begin
          irq_cnt = irq_cnt + 8'd1;
        end else begin
          irq_cnt = reload_val;
          delay_cnt = assert_delay;
        end
      end
    end
  endfunction

  function automatic rsp_word_t mapper_next_result(input req_word_t rq);
    rsp_word_t  r;
    logic [3:0] nib;
    logic       a0;
    logic [1:0] prg_idx;
    logic [3:0] chr_off;
    r = '0;
    nib = rq.address[15:12];
    a0 = |(rq.address & a0_mask);
    if (rq.req_type == REQ_TICK) begin
      advance_irq_counter();
    end else if (nib == NIB_PRG_LO || nib == NIB_PRG_HI) begin
      prg_idx = {nib[0], a0};
      if ({2'b00, prg_idx} == PRG_SLOT_SOUND) begin
        r.sound_write = 1'b1;
        r.sound_port  = |(rq.address & a1_mask);
        r.sound_data  = rq.write_data;
      end else begin
        r.bank_updated = 1'b1;
        r.bank_slot    = {2'b00, prg_idx};
        r.bank_value   = rq.write_data;
      end
    end else if (nib >= NIB_CHR_FIRST && nib <= NIB_CHR_LAST) begin
      chr_off = nib - NIB_CHR_FIRST;
      r.bank_updated = 1'b1;
      r.bank_slot    = CHR_SLOT_BASE + {1'b0, chr_off[1:0], a0};
      r.bank_value   = rq.write_data;
    end else if (nib == NIB_CTRL) begin
      if (a0) reload_val = rq.write_data;
      else ctrl_reg = rq.write_data;
    end else if (nib == NIB_IRQ) begin
      if (a0) begin
        running = restart_on_ack;
      end else begin
        restart_on_ack = rq.write_data[IRQ_RESTART_BIT];
        running        = rq.write_data[IRQ_RUN_BIT];
        cyc_mode       = rq.write_data[IRQ_CYCLE_BIT];
        if (running) begin
          presc   = '0;
          irq_cnt = reload_val;
        end
      end
      // acknowledge drops the line but leaves a pending delay running
      irq_lvl = 1'b0;
    end
    r.irq_line    = irq_lvl;
    r.mirroring   = ctrl_reg[1:0];
    r.wram_enable = ctrl_reg[WRAM_EN_BIT];
    return r;
  endfunction

  function automatic req_word_t wr(input logic [15:0] addr, input logic [7:0] data);
    req_word_t rq;
    rq.req_type   = REQ_WRITE;
    rq.address    = addr;
    rq.write_data = data;
    return rq;
  endfunction

  function automatic req_word_t tick_req();
    req_word_t rq;
    rq.req_type   = REQ_TICK;
    rq.address    = 16'($urandom);
    rq.write_data = 8'($urandom);
    return rq;
  endfunction

  // write to a nibble with the select line forced the requested way where the mask allows
  function automatic req_word_t mk_write(input logic [3:0] nib, input logic want_a0,
                                         input logic [7:0] data);
    logic [11:0] low;
    low = 12'($urandom);
    if (want_a0) low = low | a0_mask[11:0];
    else low = low & ~a0_mask[11:0];
    return wr({nib, low}, data);
  endfunction

  function automatic req_word_t noise_req();
    req_word_t rq;
    rq.req_type   = 1'($urandom);
    rq.address    = 16'($urandom);
    rq.write_data = 8'($urandom);
    if ($urandom_range(0, 4) != 0) rq.address[15] = 1'b1;
    return rq;
  endfunction

  function automatic req_word_t run_req();
    int         pick;
    logic [3:0] nib;
    pick = $urandom_range(0, 99);
    nib = 4'($urandom_range(NIB_PRG_LO, NIB_CTRL));
    if (pick < 80) return tick_req();
    if (pick < 85) return mk_write(NIB_IRQ, 1'b1, 8'($urandom));
    return mk_write(nib, 1'($urandom), 8'($urandom));
  endfunction

  function automatic logic [15:0] pick_mask();
    logic [15:0] m;
    m = 16'($urandom);
    if ($urandom_range(0, 3) != 0) m = 16'h1 << $urandom_range(0, 11);
    return m;
  endfunction

  // arm the counter, then run ticks with a few writes and acknowledges mixed in; some stretches are random noise words
  task automatic queue_phase(input int n);
    int         made;
    int         run_len;
    logic [7:0] ctl;
    logic [7:0] reload;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 3) begin
        repeat (10) pending_req_q.push_back(noise_req());
        made += 10;
      end else begin
        reload = 8'($urandom);
        if ($urandom_range(0, 9) < 7) reload[7:3] = 5'h1F;
        ctl = 8'($urandom);
        ctl[IRQ_RUN_BIT] = ($urandom_range(0, 6) != 0);
        run_len = ctl[IRQ_CYCLE_BIT] ? $urandom_range(4, 40) : $urandom_range(60, 240);
        // keep the phase close to its word budget
        if (run_len > n - made - 2) run_len = (n - made > 2) ? n - made - 2 : 0;
        pending_req_q.push_back(mk_write(NIB_CTRL, 1'b1, reload));
        pending_req_q.push_back(mk_write(NIB_IRQ, 1'b0, ctl));
        repeat (run_len) pending_req_q.push_back(run_req());
        made += run_len + 2;
      end
    end
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_A0_MASK:    a0_mask = data;
      CFG_A1_MASK:    a1_mask = data;
      CFG_ASSERT_DLY: assert_delay = data[7:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    while (pending_req_q.size() != 0 || in_valid || expected_rsp_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("word %0d: %s expected %0h, got %0h", rsp_cnt, what, exp_v, act_v);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin : req_driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_rsp_q.push_back(mapper_next_result(in_word));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_req_q.size() != 0) begin
          in_word  <= pending_req_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: short stall stretches between free runs, some of them long
  always @(posedge clk) begin : rsp_stall_gen
    logic stalling;
    stalling = out_stall;
    if (rst) begin
      stalling = 1'b0;
    end else if (rcv_left == 0) begin
      stalling = !out_stall && ($urandom_range(0, 9) < 6);
      rcv_left = stalling ? $urandom_range(1, 6)
                          : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 120 : 15);
    end else begin
      rcv_left--;
    end
    out_stall <= stalling;
  end

  always @(posedge clk) begin : rsp_monitor
    rsp_word_t want;
    if (!rst && out_valid && !out_stall) begin
      rsp_cnt++;
      if (expected_rsp_q.size() == 0) begin
        note_mismatch("unexpected word", 32'd0, 32'(out_word));
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_word.irq_line !== want.irq_line)
          note_mismatch("irq_line", 32'(want.irq_line), 32'(out_word.irq_line));
        if (out_word.bank_updated !== want.bank_updated)
          note_mismatch("bank_updated", 32'(want.bank_updated), 32'(out_word.bank_updated));
        if (out_word.bank_slot !== want.bank_slot)
          note_mismatch("bank_slot", 32'(want.bank_slot), 32'(out_word.bank_slot));
        if (out_word.bank_value !== want.bank_value)
          note_mismatch("bank_value", 32'(want.bank_value), 32'(out_word.bank_value));
        if (out_word.sound_write !== want.sound_write)
          note_mismatch("sound_write", 32'(want.sound_write), 32'(out_word.sound_write));
        if (out_word.sound_port !== want.sound_port)
          note_mismatch("sound_port", 32'(want.sound_port), 32'(out_word.sound_port));
        if (out_word.sound_data !== want.sound_data)
          note_mismatch("sound_data", 32'(want.sound_data), 32'(out_word.sound_data));
        if (out_word.mirroring !== want.mirroring)
          note_mismatch("mirroring", 32'(want.mirroring), 32'(out_word.mirroring));
        if (out_word.wram_enable !== want.wram_enable)
          note_mismatch("wram_enable", 32'(want.wram_enable), 32'(out_word.wram_enable));
      end
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [3:0] cn;
    logic [7:0] dv;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed words under reset masks: select line on bit 4, port index on bit 5
    pending_req_q.push_back(wr(16'h0000, 8'hFF));
    pending_req_q.push_back(wr(16'h7FFF, 8'h00));
    pending_req_q.push_back(wr({NIB_PRG_LO, 12'h000}, 8'hFF));
    pending_req_q.push_back(wr({NIB_PRG_LO, 12'h010}, 8'h00));
    pending_req_q.push_back(wr({NIB_PRG_HI, 12'h000}, 8'hA5));
    pending_req_q.push_back(wr({NIB_PRG_HI, 12'h010}, 8'h5A));
    pending_req_q.push_back(wr({NIB_PRG_HI, 12'h030}, 8'hC3));
    for (int i = 0; i < 8; i++) begin
      cn = NIB_CHR_FIRST + {1'b0, i[2:1]};
      dv = 8'(i * 36);
      pending_req_q.push_back(wr({cn, 7'h00, i[0], 4'h0}, dv));
    end
    pending_req_q.push_back(wr({NIB_CTRL, 12'h000}, 8'h83));
    pending_req_q.push_back(wr({NIB_CTRL, 12'h010}, 8'hFF));
    pending_req_q.push_back(wr({NIB_IRQ, 12'h000}, 8'h07));
    pending_req_q.push_back(tick_req());
    // acknowledge while the assert delay is still counting
    pending_req_q.push_back(wr({NIB_IRQ, 12'h010}, 8'h00));
    pending_req_q.push_back(tick_req());
    // stop the counter; the pending delay still raises the line
    pending_req_q.push_back(wr({NIB_IRQ, 12'h000}, 8'h00));
    pending_req_q.push_back(tick_req());
    pending_req_q.push_back(wr({NIB_IRQ, 12'h000}, 8'h02));
    pending_req_q.push_back(wr({NIB_IRQ, 12'h010}, 8'hFF));
    pending_req_q.push_back(tick_req());
    drain_and_settle();

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      case (ph)
        1: begin
          write_cfg(CFG_A0_MASK, 16'hFFFF);
          write_cfg(CFG_A1_MASK, 16'h0000);
          write_cfg(CFG_ASSERT_DLY, 16'd255);
        end
        2: begin
          // zero delay: overflows never raise the line
          write_cfg(CFG_A0_MASK, 16'h0000);
          write_cfg(CFG_A1_MASK, 16'hFFFF);
          write_cfg(CFG_ASSERT_DLY, 16'd0);
        end
        3: begin
          write_cfg(CFG_A0_MASK, 16'h0001);
          write_cfg(CFG_A1_MASK, 16'h8000);
          write_cfg(CFG_ASSERT_DLY, 16'd1);
          write_cfg(CFG_UNUSED, 16'($urandom));
        end
        default: begin
          write_cfg(CFG_A0_MASK, pick_mask());
          write_cfg(CFG_A1_MASK, pick_mask());
          write_cfg(CFG_ASSERT_DLY, 16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                                    : $urandom_range(1, 6)));
          if ($urandom_range(0, 2) == 0) write_cfg(CFG_UNUSED, 16'($urandom));
        end
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;
      queue_phase(PHASE_WORDS);
      drain_and_settle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mbir_pkg.sv
rtl/mapper_bank_and_irq_registers_core.sv
rtl/mbir_checker.sv
test/tb.sv
